// ===== rtl/core/hbe_pkg.sv =====
// hbe_pkg: shared types and constants for the huffman byte encoder
// no dependencies; imported by every module of the encoder

package hbe_pkg;

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 8;
    localparam int CODE_W   = 64;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;

    localparam int MAX_CODE_LENGTH_DEF = 64;
    localparam int SYMBOL_COUNT        = 256;
    localparam int CMDQ_DEPTH          = 4;
    localparam int OUTQ_DEPTH          = 16;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              esc;
    } t_cmd_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic [PAD_W-1:0]  pad_count;
    } t_out_item;

endpackage

// ===== rtl/core/huffman_byte_encoder.sv =====
// huffman_byte_encoder: top level of the byte-stream huffman encoder
// depends on hbe_pkg, hbe_front, hbe_back and hbe_outq
//
// input side is a queue: a transaction is taken when push is high and full
// is low. command 0 loads one table entry, 1 encodes a byte, 2 ends the
// message; command 3 is taken and ignored.
// result side is a queue: the oldest byte sits on o_out_byte, o_last_of_run
// and o_pad_count while empty is low and leaves when pop is high.
// an end transaction passes the command queue, table read and code assembly
// stages before its byte is pushed; an encode's bytes also pass the packer.
// throughput: the bit packer first merges an item's bits into its pending bits
// and then drains one finished byte per cycle while the output queue has room;
// it merges no new item until those bytes are out. an end puts out its pad
// byte in its merge cycle and loads cost no packer time.
// the 4-entry command queue keeps taking transactions while it works.
// reset clears both queues, the pending bits and the message flag; table
// entries are undefined until loaded.
// when pop stays low the 16-entry output queue fills, the packer stops,
// the command queue fills and full rises; no byte is lost.

module huffman_byte_encoder #(
    parameter int MAX_CODE_LENGTH = hbe_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [hbe_pkg::CMD_W-1:0]  i_command,
    input  logic [hbe_pkg::SYM_W-1:0]  i_symbol,
    input  logic [hbe_pkg::CODE_W-1:0] i_code_word,
    input  logic [hbe_pkg::LEN_W-1:0]  i_code_length,
    input  logic                       i_escape_flag,
    output logic                       empty,
    input  logic                       pop,
    output logic [hbe_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_of_run,
    output logic [hbe_pkg::PAD_W-1:0]  o_pad_count
);
    import hbe_pkg::*;

    logic      cmd_valid;
    t_cmd_item cmd_item;
    logic      cmd_take;
    logic      out_push;
    t_out_item out_item;
    logic      out_full;

    hbe_front #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_word   (i_code_word),
        .i_code_length (i_code_length),
        .i_escape_flag (i_escape_flag),
        .o_valid       (cmd_valid),
        .o_item        (cmd_item),
        .i_take        (cmd_take)
    );

    hbe_back #(
        .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd_valid),
        .i_item  (cmd_item),
        .o_take  (cmd_take),
        .o_push  (out_push),
        .o_item  (out_item),
        .i_full  (out_full)
    );

    hbe_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (out_push),
        .i_item        (out_item),
        .o_full        (out_full),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_pad_count   (o_pad_count)
    );

endmodule

// ===== rtl/core/hbe_front.sv =====
// hbe_front: accepts input transactions, drops unused commands, clamps code
// lengths and holds them in a short command queue; depends on hbe_pkg

module hbe_front #(
    parameter int MAX_CODE_LENGTH = hbe_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [hbe_pkg::CMD_W-1:0]   i_command,
    input  logic [hbe_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hbe_pkg::CODE_W-1:0]  i_code_word,
    input  logic [hbe_pkg::LEN_W-1:0]   i_code_length,
    input  logic                        i_escape_flag,
    output logic                        o_valid,
    output hbe_pkg::t_cmd_item          o_item,
    input  logic                        i_take
);
    import hbe_pkg::*;

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd_item        r_q [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;
    logic             enq;
    logic             deq;
    t_cmd_item        item;

    assign o_full  = (r_count == CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign accept  = i_push && !o_full;
    assign enq     = accept && (i_command != CMD_NONE);
    assign deq     = o_valid && i_take;

    always_comb begin
        item.cmd  = i_command;
        item.sym  = i_symbol;
        item.code = i_code_word;
        item.esc  = i_escape_flag;
        if (i_code_length > LEN_W'(MAX_CODE_LENGTH)) begin
            item.len = LEN_W'(MAX_CODE_LENGTH);
        end else begin
            item.len = i_code_length;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= item;
        end
    end

`ifndef SYNTH
    a_unused_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && i_command == CMD_NONE && !deq) |=> r_count == $past(r_count))
        else $error("unused command entered the queue");
`endif

endmodule

// ===== rtl/core/hbe_back.sv =====
// hbe_back: code table, table read and code assembly stages, and the bit
// packer that merges code bits with pending bits and drains whole bytes
// depends on hbe_pkg

module hbe_back #(
    parameter int MAX_CODE_LENGTH = hbe_pkg::MAX_CODE_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hbe_pkg::t_cmd_item i_item,
    output logic               o_take,
    output logic               o_push,
    output hbe_pkg::t_out_item o_item,
    input  logic               i_full
);
    import hbe_pkg::*;

    localparam int LW  = $clog2(MAX_CODE_LENGTH + 1);
    localparam int EW  = MAX_CODE_LENGTH + LW + 1;
    localparam int WW  = MAX_CODE_LENGTH + SYM_W;
    localparam int NW  = $clog2(WW + 1);
    localparam int AW  = WW + BYTE_W;
    localparam int CW  = $clog2(AW + 1);
    localparam int PCW = $clog2(BYTE_W);

    logic [EW-1:0]              r_mem [SYMBOL_COUNT];
    logic [EW-1:0]              r_rd_data;

    logic                       r_rs_valid;
    logic [CMD_W-1:0]           r_rs_cmd;
    logic [SYM_W-1:0]           r_rs_sym;

    logic                       r_xs_valid;
    logic [CMD_W-1:0]           r_xs_cmd;
    logic [WW-1:0]              r_xs_word;
    logic [NW-1:0]              r_xs_nbits;

    logic [AW-1:0]              r_acc, n_acc;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic                       r_started, n_started;

    logic                       head_load;
    logic                       rs_adv;
    logic                       rs_load;
    logic                       xs_adv;
    logic                       drain;
    logic                       end_emit;
    logic                       merge;
    logic                       hdr;
    logic [MAX_CODE_LENGTH-1:0] rd_code;
    logic [LW-1:0]              rd_len;
    logic                       rd_esc;
    logic [MAX_CODE_LENGTH-1:0] mask;
    logic [WW-1:0]              word;
    logic [NW-1:0]              nbits;
    logic [WW:0]                tword;
    logic [AW-1:0]              merged;

    assign head_load = i_valid && (i_item.cmd == CMD_LOAD);
    assign drain     = (r_cnt >= CW'(BYTE_W));
    assign end_emit  = r_started && (r_cnt != '0);
    assign merge     = r_xs_valid && !drain && (r_xs_cmd != CMD_END || !end_emit || !i_full);
    assign xs_adv    = !r_xs_valid || merge;
    assign rs_adv    = !r_rs_valid || xs_adv;
    assign o_take    = i_valid && (head_load || rs_adv);
    assign rs_load   = i_valid && !head_load && rs_adv;

    // code table
    always_ff @(posedge i_clk) begin
        if (o_take && head_load) begin
            r_mem[i_item.sym] <= {i_item.code[MAX_CODE_LENGTH-1:0], LW'(i_item.len), i_item.esc};
        end
        if (rs_load) begin
            r_rd_data <= r_mem[i_item.sym];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_valid <= 1'b0;
        end else if (rs_adv) begin
            r_rs_valid <= rs_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rs_adv) begin
            r_rs_cmd <= i_item.cmd;
            r_rs_sym <= i_item.sym;
        end
    end

    // code assembly: masked code word followed by the raw byte on escape
    assign rd_code = r_rd_data[EW-1 -: MAX_CODE_LENGTH];
    assign rd_len  = r_rd_data[LW:1];
    assign rd_esc  = r_rd_data[0];
    assign mask    = ~({MAX_CODE_LENGTH{1'b1}} << rd_len);
    assign word    = WW'(rd_code & mask) | (rd_esc ? (WW'(r_rs_sym) << rd_len) : '0);
    assign nbits   = NW'(rd_len) + (rd_esc ? NW'(SYM_W) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xs_valid <= 1'b0;
        end else if (xs_adv) begin
            r_xs_valid <= r_rs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xs_adv) begin
            r_xs_cmd   <= r_rs_cmd;
            r_xs_word  <= word;
            r_xs_nbits <= nbits;
        end
    end

    // bit packer
    assign hdr    = !r_started;
    assign tword  = hdr ? {r_xs_word, 1'b1} : {1'b0, r_xs_word};
    assign merged = AW'(r_acc[BYTE_W-2:0]) | (AW'(tword) << r_cnt[PCW-1:0]);

    always_comb begin
        n_acc              = r_acc;
        n_cnt              = r_cnt;
        n_started          = r_started;
        o_push             = 1'b0;
        o_item.out_byte    = r_acc[BYTE_W-1:0];
        o_item.last_of_run = (r_cnt < CW'(2 * BYTE_W));
        o_item.pad_count   = '0;
        if (drain) begin
            if (!i_full) begin
                o_push = 1'b1;
                n_acc  = r_acc >> BYTE_W;
                n_cnt  = r_cnt - CW'(BYTE_W);
            end
        end else if (merge) begin
            case (r_xs_cmd)
                CMD_ENCODE: begin
                    n_acc     = merged;
                    n_cnt     = CW'(r_cnt[PCW-1:0]) + CW'(r_xs_nbits) + CW'(hdr);
                    n_started = 1'b1;
                end
                CMD_END: begin
                    o_push             = end_emit;
                    o_item.out_byte    = r_acc[BYTE_W-1:0]
                                         | ({BYTE_W{1'b1}} << r_cnt[PCW-1:0]);
                    o_item.last_of_run = 1'b1;
                    o_item.pad_count   = PAD_W'(CW'(BYTE_W) - r_cnt);
                    n_acc              = '0;
                    n_cnt              = '0;
                    n_started          = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cnt     <= '0;
            r_started <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_started <= n_started;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(AW))
        else $error("packer bit count out of range");
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (merge && r_xs_cmd == CMD_END) |=> (r_cnt == '0 && !r_started))
        else $error("end of message left pending bits");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("byte pushed into full output queue");
`endif

endmodule

// ===== rtl/core/hbe_outq.sv =====
// hbe_outq: output queue that holds packed bytes until the receiver pops them
// depends on hbe_pkg

module hbe_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  hbe_pkg::t_out_item         i_item,
    output logic                       o_full,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [hbe_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last_of_run,
    output logic [hbe_pkg::PAD_W-1:0]  o_pad_count
);
    import hbe_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    t_out_item        r_q [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             enq;
    logic             deq;
    t_out_item        head;

    assign o_full        = (r_count == CNT_W'(OUTQ_DEPTH));
    assign o_empty       = (r_count == '0);
    assign enq           = i_push && !o_full;
    assign deq           = i_pop && !o_empty;
    assign head          = r_q[r_rd_ptr];
    assign o_out_byte    = head.out_byte;
    assign o_last_of_run = head.last_of_run;
    assign o_pad_count   = head.pad_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (enq) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (deq) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUTQ_DEPTH))
        else $error("output queue count out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for huffman_byte_encoder
// drives load, encode, end and unused commands through the push/full queue and checks
// every packed byte popped from the result queue against its own bit-packing predictor

module testbench;

    import hbe_pkg::*;

    localparam int MAX_LEN     = MAX_CODE_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 12;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [CMD_W-1:0]    i_command;
    logic [SYM_W-1:0]    i_symbol;
    logic [CODE_W-1:0]   i_code_word;
    logic [LEN_W-1:0]    i_code_length;
    logic                i_escape_flag;
    logic                empty;
    logic                pop;
    logic [BYTE_W-1:0]   o_out_byte;
    logic                o_last_of_run;
    logic [PAD_W-1:0]    o_pad_count;

    // predictor state
    logic [CODE_W-1:0]   tbl_code   [0:SYMBOL_COUNT-1];
    logic [LEN_W-1:0]    tbl_len    [0:SYMBOL_COUNT-1];
    logic                tbl_esc    [0:SYMBOL_COUNT-1];
    logic                tbl_loaded [0:SYMBOL_COUNT-1];
    logic [7:0]          acc_bits;
    int                  acc_count;
    logic                in_message;
    t_out_item           packed_byte_q [$];
    logic [SYM_W-1:0]    loaded_syms [$];

    int                  errors = 0;
    int                  items_sent;
    int                  bytes_checked = 0;
    int                  messages_closed;
    int                  cycle_count = 0;
    int                  stall_left;
    bit                  calm;

    huffman_byte_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_symbol      (i_symbol),
        .i_code_word   (i_code_word),
        .i_code_length (i_code_length),
        .i_escape_flag (i_escape_flag),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_pad_count   (o_pad_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // predictor
    task automatic append_byte(input logic [7:0] value, input logic [PAD_W-1:0] pad);
        t_out_item it;
        it.out_byte    = value;
        it.last_of_run = 1'b0;
        it.pad_count   = pad;
        packed_byte_q.insert(packed_byte_q.size(), it);
    endtask

    task automatic shift_in_bit(input logic b);
        acc_bits[acc_count] = b;
        if (acc_count == 7) begin
            append_byte(acc_bits, '0);
            acc_bits  = '0;
            acc_count = 0;
        end else begin
            acc_count++;
        end
    endtask

    task automatic predict_packed_bytes(
        input logic [CMD_W-1:0]  cmd,
        input logic [SYM_W-1:0]  sym,
        input logic [CODE_W-1:0] code,
        input logic [LEN_W-1:0]  len,
        input logic              esc
    );
        int        first;
        int        k;
        logic [7:0] fill;
        first = packed_byte_q.size();
        case (cmd)
            CMD_LOAD: begin
                tbl_code[sym]   = code;
                tbl_len[sym]    = (len > MAX_LEN) ? LEN_W'(MAX_LEN) : len;
                tbl_esc[sym]    = esc;
                tbl_loaded[sym] = 1'b1;
            end
            CMD_ENCODE: begin
                if (!in_message) begin
                    shift_in_bit(1'b1);
                    in_message = 1'b1;
                end
                for (k = 0; k < int'(tbl_len[sym]); k++)
                    shift_in_bit(tbl_code[sym][k]);
                if (tbl_esc[sym])
                    for (k = 0; k < 8; k++)
                        shift_in_bit(sym[k]);
            end
            CMD_END: begin
                if (in_message && acc_count != 0) begin
                    fill = 8'hFF << acc_count;
                    append_byte(acc_bits | fill, PAD_W'(8 - acc_count));
                end
                if (in_message)
                    messages_closed++;
                acc_bits   = '0;
                acc_count  = 0;
                in_message = 1'b0;
            end
            default: ;
        endcase
        if (packed_byte_q.size() > first)
            packed_byte_q[packed_byte_q.size() - 1].last_of_run = 1'b1;
    endtask

    // sends one transaction and waits until it is taken
    task automatic send_item(
        input logic [CMD_W-1:0]  cmd,
        input logic [SYM_W-1:0]  sym,
        input logic [CODE_W-1:0] code,
        input logic [LEN_W-1:0]  len,
        input logic              esc
    );
        int gap;
        @(negedge i_clk);
        push          <= 1'b1;
        i_command     <= cmd;
        i_symbol      <= sym;
        i_code_word   <= code;
        i_code_length <= len;
        i_escape_flag <= esc;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (cmd == CMD_LOAD && !tbl_loaded[sym])
            loaded_syms.insert(loaded_syms.size(), sym);
        predict_packed_bytes(cmd, sym, code, len, esc);
        if (cmd != CMD_NONE)
            items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [CODE_W-1:0] rand_code();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return LEN_W'($urandom_range(1, 12));
        else if (r < 80)
            return LEN_W'($urandom_range(13, 64));
        else if (r < 90)
            return '0;
        else
            return LEN_W'($urandom_range(65, 127));
    endfunction

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len, input logic esc);
        send_item(CMD_LOAD, sym, code, len, esc);
    endtask

    task automatic encode_byte(input logic [SYM_W-1:0] sym);
        send_item(CMD_ENCODE, sym, rand_code(), LEN_W'($urandom), 1'($urandom));
    endtask

    task automatic end_message();
        send_item(CMD_END, SYM_W'($urandom), rand_code(), LEN_W'($urandom), 1'($urandom));
    endtask

    task automatic random_load();
        load_entry(SYM_W'($urandom_range(0, 255)), rand_code(), rand_len(),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic encode_known();
        encode_byte(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (packed_byte_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_load_extremes();
        load_entry(8'h00, 64'h0, 7'd1, 1'b0);                          // shortest code
        load_entry(8'hFF, '1, 7'd64, 1'b1);                            // longest code with escape
        load_entry(8'h5A, rand_code(), 7'd0, 1'b1);                    // zero length, escape only
        load_entry(8'hA5, 64'h0123_4567_89AB_CDEF, 7'd127, 1'b0);      // clamped to max length
        load_entry(8'h3C, '1, 7'd3, 1'b0);                             // excess code bits ignored
        load_entry(8'h11, 64'h55, 7'd7, 1'b0);                         // header plus code fills a byte
        load_entry(8'h80, 64'hAAAA_5555_AAAA_5555, 7'd65, 1'b1);       // just above max length
    endtask

    task automatic test_message_edges();
        end_message();                                                 // empty message
        encode_byte(8'hFF);
        encode_byte(8'hFF);
        encode_byte(8'h3C);
        encode_byte(8'h5A);
        send_item(CMD_NONE, '1, '1, '1, 1'b1);                         // unused command
        load_entry(8'h3C, 64'h12, 7'd5, 1'b1);                         // load mid-message
        encode_byte(8'h3C);
        end_message();
        encode_byte(8'h11);                                            // aligned end
        end_message();
        encode_byte(8'h00);
        encode_byte(8'hA5);
        encode_byte(8'h80);
        end_message();
        end_message();
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        int  start;
        int  nbytes;
        int  r;
        bit  paused;
        start  = items_sent;
        paused = 1'b0;
        repeat (24) random_load();
        while (items_sent - start < n_items) begin
            if (!paused && items_sent - start >= n_items / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 75) begin
                nbytes = $urandom_range(1, 8);
                repeat (nbytes) begin
                    if ($urandom_range(0, 9) == 0)
                        random_load();
                    encode_known();
                end
                if ($urandom_range(0, 9) != 0)
                    end_message();
            end else if (r < 85) begin
                repeat ($urandom_range(1, 3)) random_load();
            end else if (r < 92) begin
                send_item(CMD_NONE, SYM_W'($urandom), rand_code(), LEN_W'($urandom),
                          1'($urandom));
            end else begin
                end_message();
            end
        end
        end_message();
    endtask

    task automatic test_calm_burst();
        calm = 1'b1;
        repeat (4) begin
            repeat ($urandom_range(2, 5)) encode_known();
            end_message();
        end
        wait_for_drain();
        calm = 1'b0;
    endtask

    // result side: random pop with stalls
    initial begin
        pop = 1'b0;
        stall_left = 0;
        forever @(negedge i_clk) begin
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_result
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (packed_byte_q.size() == 0) begin
                $error("unexpected transaction: out_byte %02h last %0b pad %0d",
                       o_out_byte, o_last_of_run, o_pad_count);
                errors++;
            end else begin
                want = packed_byte_q.pop_front();
                bytes_checked++;
                if (o_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, actual %02h", want.out_byte, o_out_byte);
                    errors++;
                end
                if (o_last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           want.last_of_run, o_last_of_run);
                    errors++;
                end
                if (o_pad_count !== want.pad_count) begin
                    $error("pad_count: expected %0d, actual %0d", want.pad_count, o_pad_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: timeout after %0d cycles", cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        push            = 1'b0;
        i_command       = CMD_NONE;
        i_symbol        = '0;
        i_code_word     = '0;
        i_code_length   = '0;
        i_escape_flag   = 1'b0;
        acc_bits        = '0;
        acc_count       = 0;
        in_message      = 1'b0;
        items_sent      = 0;
        messages_closed = 0;
        calm            = 1'b0;
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            tbl_code[s]   = '0;
            tbl_len[s]    = '0;
            tbl_esc[s]    = 1'b0;
            tbl_loaded[s] = 1'b0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_extremes();
        test_message_edges();
        test_random_traffic(220);
        test_calm_burst();
        wait_for_drain();

        $display("testbench: %0d transactions sent, %0d messages closed, %0d bytes checked",
                 items_sent, messages_closed, bytes_checked);
        $display("testbench: covered table extremes, length clamp, escapes, padding and stalls");
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
